// ----- src/abbd_pkg.sv -----
// ============================================================================
// abbd_pkg
// Shared types, widths, reset values and codes of the best-box decoder.
// ============================================================================
package abbd_pkg;

    // Default geometry of the detector grid
    localparam int unsigned DET_SIDE_DEFAULT         = 480;
    localparam int unsigned ANCHORS_PER_CELL_DEFAULT = 2;

    // Reciprocal multipliers use this many fraction bits
    localparam int unsigned RECIP_SHIFT = 16;

    // Field widths
    localparam int unsigned LEVEL_W = 2;
    localparam int unsigned INDEX_W = 13;
    localparam int unsigned SCORE_W = 16;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned KEPT_W  = 24;
    localparam int unsigned COORD_W = 28;
    localparam int unsigned BOX_W   = 32;
    localparam int unsigned INV_W   = 24;

    // Configuration port
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 3;

    // Register indexes, taken from the word address
    localparam logic REG_SCORE_THRESHOLD = 1'b0;
    localparam logic REG_INV_SCALE       = 1'b1;

    // Register reset values
    localparam logic [SCORE_W-1:0] SCORE_THRESHOLD_RESET = 16'd22938;
    localparam logic [INV_W-1:0]   INV_SCALE_RESET       = 24'd65536;

    // Feature level that carries no anchors
    localparam logic [LEVEL_W-1:0] LEVEL_UNUSED = 2'd3;

    // Input transaction
    typedef struct packed {
        logic [LEVEL_W-1:0] stride_level;
        logic [INDEX_W-1:0] anchor_index;
        logic [SCORE_W-1:0] anchor_score;
        logic [DIST_W-1:0]  dist_left;
        logic [DIST_W-1:0]  dist_top;
        logic [DIST_W-1:0]  dist_right;
        logic [DIST_W-1:0]  dist_bottom;
        logic               last;
    } anchor_t;

    // Result transaction
    typedef struct packed {
        logic                    found;
        logic [SCORE_W-1:0]      box_score;
        logic signed [BOX_W-1:0] box_left;
        logic signed [BOX_W-1:0] box_top;
        logic signed [BOX_W-1:0] box_right;
        logic signed [BOX_W-1:0] box_bottom;
    } result_t;

    // Configuration handed from the register file to the datapath
    typedef struct packed {
        logic [SCORE_W-1:0] score_threshold;
        logic [INV_W-1:0]   inv_scale;
    } cfg_t;

endpackage

// ----- src/abbd_regs.sv -----
// ============================================================================
// abbd_regs
// APB-style register file holding the score threshold and the inverse scale.
// ============================================================================
module abbd_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [abbd_pkg::ADDR_W-1:0] paddr,
    input  logic [abbd_pkg::DATA_W-1:0] pwdata,
    output logic [abbd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output abbd_pkg::cfg_t              cfg
);

    logic [abbd_pkg::SCORE_W-1:0] score_threshold_reg;
    logic [abbd_pkg::INV_W-1:0]   inv_scale_reg;
    logic                         wr_en;
    logic                         reg_sel;

    // Decode the access phase of a write
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[abbd_pkg::ADDR_W-1];

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_threshold_reg <= abbd_pkg::SCORE_THRESHOLD_RESET;
            inv_scale_reg       <= abbd_pkg::INV_SCALE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                abbd_pkg::REG_SCORE_THRESHOLD:
                begin
                    score_threshold_reg <= pwdata[abbd_pkg::SCORE_W-1:0];
                end
                abbd_pkg::REG_INV_SCALE:
                begin
                    inv_scale_reg <= pwdata[abbd_pkg::INV_W-1:0];
                end
                default:
                begin
                    score_threshold_reg <= score_threshold_reg;
                end
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (reg_sel)
            abbd_pkg::REG_SCORE_THRESHOLD:
            begin
                prdata = abbd_pkg::DATA_W'(score_threshold_reg);
            end
            abbd_pkg::REG_INV_SCALE:
            begin
                prdata = abbd_pkg::DATA_W'(inv_scale_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.score_threshold = score_threshold_reg;
    assign cfg.inv_scale       = inv_scale_reg;

endmodule

// ----- src/abbd_scale.sv -----
// ============================================================================
// abbd_scale
// Maps one kept coordinate to frame pixels: multiply by the inverse scale,
// round half up, shift out 16 fraction bits and saturate to 32 bits.
// ============================================================================
module abbd_scale
(
    input  logic signed [abbd_pkg::KEPT_W-1:0] kept_coord,
    input  logic        [abbd_pkg::INV_W-1:0]  inv_scale,
    output logic signed [abbd_pkg::BOX_W-1:0]  box_coord
);

    localparam int unsigned PROD_W = abbd_pkg::KEPT_W + abbd_pkg::INV_W + 1;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam int unsigned QUO_W  = SUM_W - abbd_pkg::RECIP_SHIFT;

    localparam logic signed [QUO_W-1:0] BOX_MAX =
        QUO_W'({1'b0, {(abbd_pkg::BOX_W-1){1'b1}}});
    localparam logic signed [QUO_W-1:0] BOX_MIN =
        -QUO_W'({1'b1, {(abbd_pkg::BOX_W-1){1'b0}}});
    localparam logic signed [SUM_W-1:0] HALF =
        SUM_W'(1) << (abbd_pkg::RECIP_SHIFT - 1);

    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;
    logic signed [QUO_W-1:0]  quo;

    // Scale and round
    assign prod = kept_coord * $signed({1'b0, inv_scale});
    assign sum  = $signed({prod[PROD_W-1], prod}) + HALF;
    assign quo  = $signed(sum[SUM_W-1:abbd_pkg::RECIP_SHIFT]);

    // Saturate to the output range
    always_comb
    begin
        if (quo > BOX_MAX)
        begin
            box_coord = $signed({1'b0, {(abbd_pkg::BOX_W-1){1'b1}}});
        end
        else if (quo < BOX_MIN)
        begin
            box_coord = $signed({1'b1, {(abbd_pkg::BOX_W-1){1'b0}}});
        end
        else
        begin
            box_coord = quo[abbd_pkg::BOX_W-1:0];
        end
    end

endmodule

// ----- src/anchor_box_best_decode_top.sv -----
// ============================================================================
// anchor_box_best_decode_top
// Keeps the best-scoring face box of a frame and emits it on the last anchor.
// ============================================================================
// Usage:
//   Anchors arrive on the anchor channel (anchor_valid / anchor_stall), one
//   transaction per anchor, the frame's final anchor flagged by last. Only
//   the last anchor produces a transaction on the result channel
//   (result_valid / result_stall): found flag, best score and the box in
//   frame pixels, or all zeros when no anchor beat the threshold.
//   Throughput is one anchor per cycle while anchor_stall is low. The
//   datapath is five registers deep: input, cell divide, row divide
//   estimate, decode and compare against the held box, and the
//   inverse-scale multiply ahead of the result register, in that order.
//   A stalled result is held in the result register while anchors keep
//   flowing; a following last anchor waits in the multiply stage, and the
//   stall reaches back to anchor_stall only once another last anchor waits at decode.
//   Reset clears the held box and empties the pipeline; the registers return
//   to threshold 0.35 and inverse scale 1.0. Write the registers over the
//   APB port only while no frame is in flight.
// ============================================================================
module anchor_box_best_decode_top
#(
    parameter int unsigned DET_SIDE         = abbd_pkg::DET_SIDE_DEFAULT,
    parameter int unsigned ANCHORS_PER_CELL = abbd_pkg::ANCHORS_PER_CELL_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        anchor_valid,
    output logic                        anchor_stall,
    input  abbd_pkg::anchor_t           anchor,
    output logic                        result_valid,
    input  logic                        result_stall,
    output abbd_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [abbd_pkg::ADDR_W-1:0] paddr,
    input  logic [abbd_pkg::DATA_W-1:0] pwdata,
    output logic [abbd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    // Grid constants, worked out at elaboration
    localparam int unsigned SIDE0      = DET_SIDE / 8;
    localparam int unsigned SIDE1      = DET_SIDE / 16;
    localparam int unsigned SIDE2      = DET_SIDE / 32;
    localparam int unsigned RECIP_ONE  = 1 << abbd_pkg::RECIP_SHIFT;
    localparam int unsigned RECIP_S0   = RECIP_ONE / SIDE0;
    localparam int unsigned RECIP_S1   = RECIP_ONE / SIDE1;
    localparam int unsigned RECIP_S2   = RECIP_ONE / SIDE2;
    localparam int unsigned RECIP_A    =
        (RECIP_ONE + ANCHORS_PER_CELL - 1) / ANCHORS_PER_CELL;
    localparam int unsigned RA_W       = abbd_pkg::RECIP_SHIFT + 1;
    localparam int unsigned RS_W       = abbd_pkg::RECIP_SHIFT;
    localparam int unsigned IW         = abbd_pkg::INDEX_W;
    localparam int unsigned SIDE_W     = $clog2(SIDE0 + 1);
    localparam int unsigned REM_W      = SIDE_W + 1;
    localparam int unsigned QS_W       = IW + SIDE_W;
    localparam int unsigned CW         = abbd_pkg::COORD_W;
    localparam int unsigned KW         = abbd_pkg::KEPT_W;

    localparam logic signed [CW-1:0] KEPT_MAX = CW'((1 << (KW - 1)) - 1);
    localparam logic signed [CW-1:0] KEPT_MIN = -CW'(1 << (KW - 1));

    // Clamp a decoded coordinate to the kept width
    function automatic logic signed [KW-1:0] sat_kept(input logic signed [CW-1:0] v);
        logic signed [KW-1:0] r;
        if (v > KEPT_MAX)
        begin
            r = KEPT_MAX[KW-1:0];
        end
        else if (v < KEPT_MIN)
        begin
            r = KEPT_MIN[KW-1:0];
        end
        else
        begin
            r = v[KW-1:0];
        end
        return r;
    endfunction

    // Widen the index for the cell divide
    function automatic logic [IW+RA_W-1:0] anchor_index_ext(input logic [IW-1:0] idx);
        return (IW + RA_W)'(idx);
    endfunction

    abbd_pkg::cfg_t cfg;

    // Pipeline control
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, result_v_reg;
    logic out_free, s4_free, s3_move, s3_free, s2_free, s1_free;

    // Pipeline payload
    abbd_pkg::anchor_t s1_reg, s2_reg, s3_reg;
    logic [IW-1:0]     s2_cell_reg, s3_cell_reg, s3_q_reg;

    // Held box of the current frame
    logic                         have_box_reg, have_box_next;
    logic [abbd_pkg::SCORE_W-1:0] kept_score_reg, kept_score_next;
    logic signed [KW-1:0]         kept_left_reg, kept_left_next;
    logic signed [KW-1:0]         kept_top_reg, kept_top_next;
    logic signed [KW-1:0]         kept_right_reg, kept_right_next;
    logic signed [KW-1:0]         kept_bottom_reg, kept_bottom_next;

    // Frame snapshot for scaling
    logic                         s4_found_reg;
    logic [abbd_pkg::SCORE_W-1:0] s4_score_reg;
    logic signed [KW-1:0]         s4_left_reg, s4_top_reg, s4_right_reg, s4_bottom_reg;

    // Stage combinational signals
    logic [IW+RA_W-1:0]     prod_a;
    logic [IW-1:0]          cell_s1;
    logic [RS_W-1:0]        recip_s2;
    logic [IW+RS_W-1:0]     prod_s;
    logic [IW-1:0]          q_est_s2;
    logic [SIDE_W-1:0]      side_s3;
    logic [QS_W-1:0]        qs_s3;
    logic [QS_W-1:0]        rem_wide;
    logic [REM_W-1:0]       rem_raw;
    logic [REM_W-1:0]       col_s3;
    logic [IW-1:0]          row_s3;
    logic [2:0]             stride_sh;
    logic [CW-1:0]          cx, cy, dl_px, dt_px, dr_px, db_px;
    logic signed [KW-1:0]   new_left, new_top, new_right, new_bottom;
    logic [abbd_pkg::SCORE_W-1:0] best_s3;
    logic                   take;
    logic                   snap_have;
    logic [abbd_pkg::SCORE_W-1:0] snap_score;
    logic signed [KW-1:0]   snap_left, snap_top, snap_right, snap_bottom;
    logic signed [abbd_pkg::BOX_W-1:0] box_left_c, box_top_c, box_right_c, box_bottom_c;

    abbd_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance control: each stage loads when it is empty or draining
    assign out_free     = !result_v_reg || !result_stall;
    assign s4_free      = !s4_v_reg || out_free;
    assign s3_move      = s3_v_reg && (!s3_reg.last || s4_free);
    assign s3_free      = !s3_v_reg || s3_move;
    assign s2_free      = !s2_v_reg || s3_free;
    assign s1_free      = !s1_v_reg || s2_free;
    assign anchor_stall = !s1_free;
    assign result_valid = result_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            s4_v_reg     <= 1'b0;
            result_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_v_reg <= anchor_valid;
            end
            if (s2_free)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_free)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (s4_free)
            begin
                s4_v_reg <= s3_v_reg && s3_reg.last;
            end
            if (out_free)
            begin
                result_v_reg <= s4_v_reg;
            end
        end
    end

    // Stage 1: divide the index by the anchors per cell
    assign prod_a  = anchor_index_ext(s1_reg.anchor_index) * RA_W'(RECIP_A);
    assign cell_s1 = prod_a[IW+abbd_pkg::RECIP_SHIFT-1:abbd_pkg::RECIP_SHIFT];

    // Stage 2: estimate the row by the reciprocal of the grid side
    always_comb
    begin
        case (s2_reg.stride_level)
            2'd1:    recip_s2 = RS_W'(RECIP_S1);
            2'd2:    recip_s2 = RS_W'(RECIP_S2);
            default: recip_s2 = RS_W'(RECIP_S0);
        endcase
    end

    assign prod_s   = (IW + RS_W)'(s2_cell_reg) * (IW + RS_W)'(recip_s2);
    assign q_est_s2 = prod_s[IW+abbd_pkg::RECIP_SHIFT-1:abbd_pkg::RECIP_SHIFT];

    // Stage 3: correct the row, find the column and decode the box
    always_comb
    begin
        case (s3_reg.stride_level)
            2'd1:    side_s3 = SIDE_W'(SIDE1);
            2'd2:    side_s3 = SIDE_W'(SIDE2);
            default: side_s3 = SIDE_W'(SIDE0);
        endcase
    end

    assign qs_s3    = QS_W'(s3_q_reg) * QS_W'(side_s3);
    assign rem_wide = QS_W'(s3_cell_reg) - qs_s3;
    assign rem_raw  = rem_wide[REM_W-1:0];

    always_comb
    begin
        if (rem_raw >= REM_W'(side_s3))
        begin
            col_s3 = rem_raw - REM_W'(side_s3);
            row_s3 = s3_q_reg + IW'(1);
        end
        else
        begin
            col_s3 = rem_raw;
            row_s3 = s3_q_reg;
        end
    end

    assign stride_sh = 3'd3 + 3'(s3_reg.stride_level);
    assign cx    = CW'(col_s3) << (4'(stride_sh) + 4'd8);
    assign cy    = CW'(row_s3) << (4'(stride_sh) + 4'd8);
    assign dl_px = CW'(s3_reg.dist_left) << stride_sh;
    assign dt_px = CW'(s3_reg.dist_top) << stride_sh;
    assign dr_px = CW'(s3_reg.dist_right) << stride_sh;
    assign db_px = CW'(s3_reg.dist_bottom) << stride_sh;

    assign new_left   = sat_kept($signed(cx) - $signed(dl_px));
    assign new_top    = sat_kept($signed(cy) - $signed(dt_px));
    assign new_right  = sat_kept($signed(cx) + $signed(dr_px));
    assign new_bottom = sat_kept($signed(cy) + $signed(db_px));

    // Compare against the running best
    assign best_s3 = have_box_reg ? kept_score_reg : cfg.score_threshold;
    assign take    = (s3_reg.stride_level != abbd_pkg::LEVEL_UNUSED)
                     && (s3_reg.anchor_score > best_s3);

    assign snap_have   = have_box_reg || take;
    assign snap_score  = take ? s3_reg.anchor_score : kept_score_reg;
    assign snap_left   = take ? new_left   : kept_left_reg;
    assign snap_top    = take ? new_top    : kept_top_reg;
    assign snap_right  = take ? new_right  : kept_right_reg;
    assign snap_bottom = take ? new_bottom : kept_bottom_reg;

    // Update the held box; clear it once the frame's last anchor leaves
    always_comb
    begin
        have_box_next    = have_box_reg;
        kept_score_next  = kept_score_reg;
        kept_left_next   = kept_left_reg;
        kept_top_next    = kept_top_reg;
        kept_right_next  = kept_right_reg;
        kept_bottom_next = kept_bottom_reg;
        if (s3_move)
        begin
            if (s3_reg.last)
            begin
                have_box_next    = 1'b0;
                kept_score_next  = '0;
                kept_left_next   = '0;
                kept_top_next    = '0;
                kept_right_next  = '0;
                kept_bottom_next = '0;
            end
            else
            begin
                have_box_next    = snap_have;
                kept_score_next  = snap_score;
                kept_left_next   = snap_left;
                kept_top_next    = snap_top;
                kept_right_next  = snap_right;
                kept_bottom_next = snap_bottom;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_box_reg    <= 1'b0;
            kept_score_reg  <= '0;
            kept_left_reg   <= '0;
            kept_top_reg    <= '0;
            kept_right_reg  <= '0;
            kept_bottom_reg <= '0;
        end
        else
        begin
            have_box_reg    <= have_box_next;
            kept_score_reg  <= kept_score_next;
            kept_left_reg   <= kept_left_next;
            kept_top_reg    <= kept_top_next;
            kept_right_reg  <= kept_right_next;
            kept_bottom_reg <= kept_bottom_next;
        end
    end

    // Stage 4: scale the snapshot to frame pixels
    abbd_scale u_scale_left
    (
        .kept_coord (s4_left_reg),
        .inv_scale  (cfg.inv_scale),
        .box_coord  (box_left_c)
    );

    abbd_scale u_scale_top
    (
        .kept_coord (s4_top_reg),
        .inv_scale  (cfg.inv_scale),
        .box_coord  (box_top_c)
    );

    abbd_scale u_scale_right
    (
        .kept_coord (s4_right_reg),
        .inv_scale  (cfg.inv_scale),
        .box_coord  (box_right_c)
    );

    abbd_scale u_scale_bottom
    (
        .kept_coord (s4_bottom_reg),
        .inv_scale  (cfg.inv_scale),
        .box_coord  (box_bottom_c)
    );

    // Load payload registers as their stage advances
    always_ff @(posedge clk)
    begin
        if (s1_free && anchor_valid)
        begin
            s1_reg <= anchor;
        end
        if (s2_free && s1_v_reg)
        begin
            s2_reg      <= s1_reg;
            s2_cell_reg <= cell_s1;
        end
        if (s3_free && s2_v_reg)
        begin
            s3_reg      <= s2_reg;
            s3_cell_reg <= s2_cell_reg;
            s3_q_reg    <= q_est_s2;
        end
        if (s4_free && s3_v_reg && s3_reg.last)
        begin
            s4_found_reg  <= snap_have;
            s4_score_reg  <= snap_score;
            s4_left_reg   <= snap_left;
            s4_top_reg    <= snap_top;
            s4_right_reg  <= snap_right;
            s4_bottom_reg <= snap_bottom;
        end
        if (out_free && s4_v_reg)
        begin
            result.found      <= s4_found_reg;
            result.box_score  <= s4_score_reg;
            result.box_left   <= box_left_c;
            result.box_top    <= box_top_c;
            result.box_right  <= box_right_c;
            result.box_bottom <= box_bottom_c;
        end
    end

    // Checks on the held box and the emitted result
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_move && s3_reg.last) |=> !have_box_reg)
        else $error("held box not cleared after the last anchor");

    a_held_score: assert property (@(posedge clk) disable iff (!rst_n)
        have_box_reg == (kept_score_reg != '0))
        else $error("held flag disagrees with the held score");

    a_found_score: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.found) |-> (result.box_score != '0))
        else $error("found result carries a zero score");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.found) |->
            (result.box_score == '0 && result.box_left == '0 &&
             result.box_bottom == '0))
        else $error("empty result carries a box");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the best-box decoder: anchor frames go in, one
// result per frame comes out and is checked against a predicted best box.
// Directed frames cover field extremes, ties, the unused level, indexes
// outside the grid and threshold changes mid-frame. Random phases follow,
// each under its own register setting, random idling except in a calm phase.
// ============================================================================
import abbd_pkg::*;

class frame_box_scoreboard;

    localparam longint KEPT_MAX = (longint'(1) << (KEPT_W - 1)) - 1;
    localparam longint KEPT_MIN = -(longint'(1) << (KEPT_W - 1));
    localparam longint BOX_MAX  = (longint'(1) << (BOX_W - 1)) - 1;
    localparam longint BOX_MIN  = -(longint'(1) << (BOX_W - 1));

    // Register copies
    logic [SCORE_W-1:0] threshold;
    logic [INV_W-1:0]   inv_scale;

    // Box held for the current frame
    bit                 held;
    logic [SCORE_W-1:0] held_score;
    longint             held_l, held_t, held_r, held_b;

    result_t            frame_results_due[$];
    int                 errors;
    int                 anchors_seen;
    int                 results_checked;
    int                 boxes_found;
    int                 reg_writes;

    function new();
        threshold       = SCORE_THRESHOLD_RESET;
        inv_scale       = INV_SCALE_RESET;
        held            = 1'b0;
        held_score      = '0;
        held_l          = 0;
        held_t          = 0;
        held_r          = 0;
        held_b          = 0;
        errors          = 0;
        anchors_seen    = 0;
        results_checked = 0;
        boxes_found     = 0;
        reg_writes      = 0;
    endfunction

    function void set_reg(logic idx, logic [DATA_W-1:0] value);
        reg_writes++;
        if (idx == REG_SCORE_THRESHOLD)
            threshold = value[SCORE_W-1:0];
        else
            inv_scale = value[INV_W-1:0];
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Map a held coordinate to frame pixels: round half up, then saturate
    function logic signed [BOX_W-1:0] to_frame(longint c);
        longint p;
        p = c * longint'(inv_scale) + 32768;
        return BOX_W'(clamp(p >>> RECIP_SHIFT, BOX_MIN, BOX_MAX));
    endfunction

    function void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Track one accepted anchor; queue a result when it closes the frame
    function void track_anchor(anchor_t a);
        logic [SCORE_W-1:0] bar;
        longint             stride, side, cell_no, cx, cy;
        result_t            due;
        anchors_seen++;
        bar = held ? held_score : threshold;
        if (a.stride_level != LEVEL_UNUSED && a.anchor_score > bar)
        begin
            stride  = longint'(8) << a.stride_level;
            side    = longint'(DET_SIDE_DEFAULT) / stride;
            cell_no = longint'(a.anchor_index) / longint'(ANCHORS_PER_CELL_DEFAULT);
            cx      = (cell_no % side) * stride * 256;
            cy      = (cell_no / side) * stride * 256;
            held_l = clamp(cx - longint'(a.dist_left) * stride, KEPT_MIN, KEPT_MAX);
            held_t = clamp(cy - longint'(a.dist_top) * stride, KEPT_MIN, KEPT_MAX);
            held_r = clamp(cx + longint'(a.dist_right) * stride, KEPT_MIN, KEPT_MAX);
            held_b = clamp(cy + longint'(a.dist_bottom) * stride, KEPT_MIN, KEPT_MAX);
            held_score = a.anchor_score;
            held = 1'b1;
        end
        if (a.last)
        begin
            due = '0;
            if (held)
            begin
                due.found      = 1'b1;
                due.box_score  = held_score;
                due.box_left   = to_frame(held_l);
                due.box_top    = to_frame(held_t);
                due.box_right  = to_frame(held_r);
                due.box_bottom = to_frame(held_b);
            end
            frame_results_due = {frame_results_due, due};
            held       = 1'b0;
            held_score = '0;
            held_l     = 0;
            held_t     = 0;
            held_r     = 0;
            held_b     = 0;
        end
    endfunction

    // Compare one accepted result with the oldest frame still due
    function void check_result(result_t r);
        result_t due;
        if (frame_results_due.size() == 0)
        begin
            errors++;
            $display("%0t: result arrived with no frame pending", $time);
            return;
        end
        due = frame_results_due.pop_front();
        results_checked++;
        if (r.found)
            boxes_found++;
        check_field("found", due.found, r.found);
        check_field("box_score", due.box_score, r.box_score);
        check_field("box_left", due.box_left, r.box_left);
        check_field("box_top", due.box_top, r.box_top);
        check_field("box_right", due.box_right, r.box_right);
        check_field("box_bottom", due.box_bottom, r.box_bottom);
    endfunction

endclass

module tb;

    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 144;
    localparam int HOLD_PHASE     = 4;
    localparam int CALM_PHASE     = 5;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                clk;
    logic                rst_n;
    logic                anchor_valid;
    logic                anchor_stall;
    anchor_t             anchor;
    logic                result_valid;
    logic                result_stall;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Idling control: calm for the sender and the receiver, hold_armed for the receiver
    bit                  calm;
    bit                  hold_armed;

    frame_box_scoreboard sb;

    anchor_box_best_decode_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .anchor_valid (anchor_valid),
        .anchor_stall (anchor_stall),
        .anchor       (anchor),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic anchor_t make_anchor(int lvl, int idx, int score,
                                            int dl, int dt, int dr, int db, bit fin);
        anchor_t a;
        a.stride_level = LEVEL_W'(lvl);
        a.anchor_index = INDEX_W'(idx);
        a.anchor_score = SCORE_W'(score);
        a.dist_left    = DIST_W'(dl);
        a.dist_top     = DIST_W'(dt);
        a.dist_right   = DIST_W'(dr);
        a.dist_bottom  = DIST_W'(db);
        a.last         = fin;
        return a;
    endfunction

    // Offer one anchor after a random gap and hold it until accepted
    task automatic send_anchor(input anchor_t a);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 20)
        begin
            anchor_valid <= 1'b0;
            @(negedge clk);
        end
        anchor       <= a;
        anchor_valid <= 1'b1;
        do @(posedge clk); while (anchor_stall);
        sb.track_anchor(a);
    endtask

    // Read a register and compare it with the value it should hold
    task automatic reg_read_check(input logic idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] mask;
        mask = (idx == REG_INV_SCALE) ? DATA_W'({INV_W{1'b1}}) : DATA_W'({SCORE_W{1'b1}});
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.check_field("register readback", value & mask, prdata & mask);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_write(input logic idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        reg_read_check(idx, value);
    endtask

    // Drop valid, wait for every due result, then let the pipeline empty
    task automatic drain_pipeline();
        @(negedge clk);
        anchor_valid <= 1'b0;
        while (sb.frame_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls, one long hold-off when armed
    initial
    begin : result_sink
        int hold_left;
        bit hold_used;
        hold_left    = 0;
        hold_used    = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !calm && ($urandom_range(99) < 20);
        end
    end

    // Check every accepted result transaction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        do
        begin
            @(posedge clk);
            if ((anchor_valid && !anchor_stall) || (result_valid && !result_stall) || psel)
                quiet = 0;
            else
                quiet++;
        end
        while (quiet < WATCHDOG_LIMIT);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb failed");
        $finish;
    end

    initial
    begin : stimulus
        anchor_t            a;
        logic [SCORE_W-1:0] thr;
        logic [INV_W-1:0]   inv;
        int                 p, k, sent, flen, lvl, side, s;

        sb           = new();
        rst_n        = 1'b0;
        anchor_valid = 1'b0;
        anchor       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        reg_read_check(REG_SCORE_THRESHOLD, DATA_W'(SCORE_THRESHOLD_RESET));
        reg_read_check(REG_INV_SCALE, DATA_W'(INV_SCALE_RESET));

        // Nothing above the threshold, and a strong anchor on the unused level
        send_anchor(make_anchor(0, 0, 0, 0, 0, 0, 0, 1));
        send_anchor(make_anchor(LEVEL_UNUSED, 100, 65535, 100, 100, 100, 100, 1));

        // Score equal to threshold loses; a tie keeps the first box
        send_anchor(make_anchor(0, 5, SCORE_THRESHOLD_RESET, 9, 9, 9, 9, 0));
        send_anchor(make_anchor(1, 40, 30000, 256, 512, 768, 1024, 0));
        send_anchor(make_anchor(2, 3, 30000, 1, 2, 3, 4, 0));
        send_anchor(make_anchor(0, 7199, 29999, 5, 6, 7, 8, 1));

        // Field extremes and an index past the grid
        send_anchor(make_anchor(2, 8191, 65535, 65535, 65535, 65535, 65535, 1));
        send_anchor(make_anchor(0, 7199, SCORE_THRESHOLD_RESET + 1, 0, 0, 0, 0, 1));

        // Frame closed by an unused-level anchor keeps the earlier box
        send_anchor(make_anchor(1, 1799, 40000, 4660, 22136, 39612, 57072, 0));
        send_anchor(make_anchor(LEVEL_UNUSED, 0, 65535, 0, 0, 0, 0, 1));

        // Threshold lowered mid-frame while no box is held
        send_anchor(make_anchor(0, 10, 10000, 300, 300, 300, 300, 0));
        drain_pipeline();
        reg_write(REG_SCORE_THRESHOLD, 32'd5000);
        send_anchor(make_anchor(0, 11, 8000, 300, 400, 500, 600, 1));

        // Threshold raised mid-frame while a box is held
        send_anchor(make_anchor(1, 20, 30000, 700, 800, 900, 1000, 0));
        drain_pipeline();
        reg_write(REG_SCORE_THRESHOLD, 32'd60000);
        send_anchor(make_anchor(1, 21, 40000, 10, 20, 30, 40, 1));

        // Largest scale on the largest box; zero threshold against zero score
        drain_pipeline();
        reg_write(REG_SCORE_THRESHOLD, 32'd0);
        reg_write(REG_INV_SCALE, DATA_W'({INV_W{1'b1}}));
        send_anchor(make_anchor(2, 8191, 1, 65535, 65535, 65535, 65535, 1));
        send_anchor(make_anchor(0, 0, 0, 65535, 65535, 65535, 65535, 1));

        // Zero scale; top threshold admits nothing
        drain_pipeline();
        reg_write(REG_SCORE_THRESHOLD, DATA_W'({SCORE_W{1'b1}}));
        reg_write(REG_INV_SCALE, 32'd0);
        send_anchor(make_anchor(0, 0, 65535, 1, 1, 1, 1, 1));
        drain_pipeline();
        reg_write(REG_SCORE_THRESHOLD, 32'd65534);
        send_anchor(make_anchor(1, 2, 65535, 1234, 2345, 3456, 4567, 1));

        // Random frames, one register setting per phase
        for (p = 0; p < PHASES; p++)
        begin
            drain_pipeline();
            case (p)
                0: thr = SCORE_THRESHOLD_RESET;
                1: thr = '0;
                2: thr = '1;
                default: thr = SCORE_W'($urandom_range(0, 50000));
            endcase
            case (p)
                0: inv = INV_SCALE_RESET;
                1: inv = '1;
                2: inv = '0;
                3: inv = INV_W'(1);
                6: inv = INV_W'($urandom_range(0, 24'hFFFFFF));
                default: inv = INV_W'($urandom_range(16384, 262144));
            endcase
            reg_write(REG_SCORE_THRESHOLD, DATA_W'(thr));
            reg_write(REG_INV_SCALE, DATA_W'(inv));
            calm = (p == CALM_PHASE);
            if (p == HOLD_PHASE)
                hold_armed = 1'b1;

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                flen = (p == HOLD_PHASE) ? $urandom_range(1, 2) : $urandom_range(1, 10);
                for (k = 0; k < flen; k++)
                begin
                    lvl = ($urandom_range(99) < 5) ? LEVEL_UNUSED : $urandom_range(0, 2);
                    a.stride_level = LEVEL_W'(lvl);
                    // Mostly inside the level's grid, sometimes anywhere
                    if (lvl == LEVEL_UNUSED || $urandom_range(99) < 15)
                        a.anchor_index = INDEX_W'($urandom_range(0, 8191));
                    else
                    begin
                        side = DET_SIDE_DEFAULT >> (3 + lvl);
                        a.anchor_index = INDEX_W'($urandom_range(0,
                                         ANCHORS_PER_CELL_DEFAULT * side * side - 1));
                    end
                    // Half the scores sit right around the threshold
                    if ($urandom_range(1) == 0)
                        s = $urandom_range(0, 65535);
                    else
                    begin
                        s = int'(thr) + int'($urandom_range(0, 6)) - 3;
                        if (s < 0)
                            s = 0;
                        if (s > 65535)
                            s = 65535;
                    end
                    a.anchor_score = SCORE_W'(s);
                    if ($urandom_range(99) < 25)
                    begin
                        a.dist_left   = DIST_W'($urandom_range(0, 2047));
                        a.dist_top    = DIST_W'($urandom_range(0, 2047));
                        a.dist_right  = DIST_W'($urandom_range(0, 2047));
                        a.dist_bottom = DIST_W'($urandom_range(0, 2047));
                    end
                    else
                    begin
                        a.dist_left   = DIST_W'($urandom_range(0, 65535));
                        a.dist_top    = DIST_W'($urandom_range(0, 65535));
                        a.dist_right  = DIST_W'($urandom_range(0, 65535));
                        a.dist_bottom = DIST_W'($urandom_range(0, 65535));
                    end
                    a.last = (k == flen - 1);
                    send_anchor(a);
                    sent++;
                end
            end
        end

        drain_pipeline();
        calm = 1'b0;
        repeat (20) @(posedge clk);

        $display("Run covered %0d anchors and %0d frame results, %0d of them with a box,",
                 sb.anchors_seen, sb.results_checked, sb.boxes_found);
        $display("under %0d register writes including both extremes of each register.",
                 sb.reg_writes);
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/abbd_pkg.sv
src/abbd_regs.sv
src/abbd_scale.sv
src/anchor_box_best_decode_top.sv
test/tb.sv
